// ===== rtl/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    // Number of decimal digit stages and size of the character line
    localparam int NDIG = 10;
    localparam int NBUF = 11;

    typedef logic [7:0] t_char;
    typedef logic [3:0] t_idx;

    // Conversion kinds, carried on the input tuser
    typedef enum logic [2:0] {
        CMD_DEC_S16 = 3'd0,
        CMD_DEC_U16 = 3'd1,
        CMD_DEC_S32 = 3'd2,
        CMD_DEC_U32 = 3'd3,
        CMD_HEX_LO  = 3'd4,
        CMD_HEX_UP  = 3'd5,
        CMD_PTR     = 3'd6,
        CMD_CHAR    = 3'd7
    } t_cmd;

    localparam t_char C_ZERO  = 8'h30;
    localparam t_char C_MINUS = 8'h2D;
    localparam t_char C_UP_A  = 8'h41;
    localparam t_char C_LO_A  = 8'h61;

    // Slot of the final character in the line
    localparam t_idx C_LAST_IDX = t_idx'(NBUF - 1);

    // First slot for the fixed-length kinds
    localparam t_idx C_FIRST_HEX4 = t_idx'(NBUF - 4);
    localparam t_idx C_FIRST_HEX2 = t_idx'(NBUF - 2);
    localparam t_idx C_FIRST_PTR  = t_idx'(NBUF - 5);
    localparam t_idx C_FIRST_CHAR = t_idx'(NBUF - 1);

    // Powers of ten, most significant digit first
    localparam logic [31:0] C_POW10 [NDIG] = '{
        32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000, 32'd100000,
        32'd10000, 32'd1000, 32'd100, 32'd10, 32'd1
    };

    // Context that rides along the digit pipeline
    typedef struct packed {
        logic           is_dec;
        logic           neg;
        t_char [4:0]    fix;        // fix[0] is the final character
        t_idx           fix_first;
    } t_ctx;

    // One digit pipeline stage
    typedef struct packed {
        t_ctx           ctx;
        logic [31:0]    mag;
        logic [4*NDIG-1:0] digs;    // digits shifted in, most significant first
    } t_dstage;

    // Finished character line handed to the serializer
    typedef struct packed {
        t_char [NBUF-1:0] chars;
        t_idx             first;
    } t_line;

    function automatic t_char hex_char(input logic [3:0] nib, input logic upper);
        t_char base;
        base = upper ? C_UP_A : C_LO_A;
        if (nib < 4'd10) begin
            return C_ZERO + {4'b0, nib};
        end
        return base + {4'b0, nib} - 8'd10;
    endfunction

endpackage

// ===== rtl/i2a_prep.sv =====
// ----------------------------------------------------------------------------
// i2a_prep
// Entry stage: decodes the request, forms the decimal magnitude and sign,
// and builds the characters of the fixed-length kinds.
// ----------------------------------------------------------------------------
module i2a_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2a_pkg::t_cmd       i_cmd,
    input  logic [31:0]         i_value,
    input  logic [3:0]          i_width,
    input  logic                i_out_en,
    output logic                o_valid,
    output i2a_pkg::t_dstage    o_st,
    input  logic                i_ready
);

    logic               r_v;
    i2a_pkg::t_dstage   r_st;
    i2a_pkg::t_dstage   n_st;
    logic               w_take;
    logic [15:0]        w_neg16;
    logic               w_wide;

    assign o_ready = !r_v || i_ready;
    // drop the beat when output is disabled
    assign w_take  = i_valid && i_out_en;
    assign w_neg16 = 16'd0 - i_value[15:0];
    assign w_wide  = (i_width == 4'd0) || (i_width == 4'd4);

    // decode the request
    always_comb begin
        n_st               = '0;
        n_st.ctx.fix_first = i2a_pkg::C_LAST_IDX;
        case (i_cmd)
            i2a_pkg::CMD_DEC_S16: begin
                n_st.ctx.is_dec = 1'b1;
                n_st.ctx.neg    = i_value[15];
                n_st.mag        = i_value[15] ? {16'd0, w_neg16} : {16'd0, i_value[15:0]};
            end
            i2a_pkg::CMD_DEC_U16: begin
                n_st.ctx.is_dec = 1'b1;
                n_st.mag        = {16'd0, i_value[15:0]};
            end
            i2a_pkg::CMD_DEC_S32: begin
                n_st.ctx.is_dec = 1'b1;
                n_st.ctx.neg    = i_value[31];
                n_st.mag        = i_value[31] ? (32'd0 - i_value) : i_value;
            end
            i2a_pkg::CMD_DEC_U32: begin
                n_st.ctx.is_dec = 1'b1;
                n_st.mag        = i_value;
            end
            i2a_pkg::CMD_HEX_LO, i2a_pkg::CMD_HEX_UP: begin
                n_st.ctx.fix[0] = i2a_pkg::hex_char(i_value[3:0],
                                                    i_cmd == i2a_pkg::CMD_HEX_UP);
                n_st.ctx.fix[1] = i2a_pkg::hex_char(i_value[7:4],
                                                    i_cmd == i2a_pkg::CMD_HEX_UP);
                n_st.ctx.fix[2] = i2a_pkg::hex_char(i_value[11:8],
                                                    i_cmd == i2a_pkg::CMD_HEX_UP);
                n_st.ctx.fix[3] = i2a_pkg::hex_char(i_value[15:12],
                                                    i_cmd == i2a_pkg::CMD_HEX_UP);
                n_st.ctx.fix_first = w_wide ? i2a_pkg::C_FIRST_HEX4
                                            : i2a_pkg::C_FIRST_HEX2;
            end
            i2a_pkg::CMD_PTR: begin
                n_st.ctx.fix[0]    = i2a_pkg::hex_char(i_value[3:0], 1'b1);
                n_st.ctx.fix[1]    = i2a_pkg::hex_char(i_value[7:4], 1'b1);
                n_st.ctx.fix[2]    = i2a_pkg::hex_char(i_value[11:8], 1'b1);
                n_st.ctx.fix[3]    = i2a_pkg::hex_char(i_value[15:12], 1'b1);
                n_st.ctx.fix[4]    = i2a_pkg::hex_char(i_value[19:16], 1'b1);
                n_st.ctx.fix_first = i2a_pkg::C_FIRST_PTR;
            end
            i2a_pkg::CMD_CHAR: begin
                n_st.ctx.fix[0]    = i_value[7:0];
                n_st.ctx.fix_first = i2a_pkg::C_FIRST_CHAR;
            end
            default: begin
                n_st.ctx.fix[0]    = i_value[7:0];
                n_st.ctx.fix_first = i2a_pkg::C_FIRST_CHAR;
            end
        endcase
    end

    // hold while the next stage stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && w_take) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_v;
    assign o_st    = r_st;

endmodule

// ===== rtl/i2a_digits.sv =====
// ----------------------------------------------------------------------------
// i2a_digits
// Decimal digit pipeline: one register stage per power of ten, each stage
// finds its digit by comparing against the nine multiples and subtracting.
// ----------------------------------------------------------------------------
module i2a_digits (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2a_pkg::t_dstage    i_st,
    output logic                o_valid,
    output i2a_pkg::t_dstage    o_st,
    input  logic                i_ready
);

    logic               r_v   [i2a_pkg::NDIG];
    i2a_pkg::t_dstage   r_st  [i2a_pkg::NDIG];
    i2a_pkg::t_dstage   n_st  [i2a_pkg::NDIG];
    i2a_pkg::t_dstage   w_in  [i2a_pkg::NDIG];
    logic               w_vin [i2a_pkg::NDIG];
    logic               w_rdy [i2a_pkg::NDIG+1];

    assign w_rdy[i2a_pkg::NDIG] = i_ready;
    assign w_in[0]              = i_st;
    assign w_vin[0]             = i_valid;

    for (genvar j = 0; j < i2a_pkg::NDIG; j++) begin : g_stage
        logic [8:0]  w_ge;
        logic [31:0] w_sub;
        logic [3:0]  w_dig;

        if (j > 0) begin : g_link
            assign w_in[j]  = r_st[j-1];
            assign w_vin[j] = r_v[j-1];
        end

        // collapse bubbles: a stage advances when empty or drained
        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];

        // compare against every multiple of this power of ten
        always_comb begin
            w_sub = '0;
            for (int m = 1; m <= 9; m++) begin
                w_ge[m-1] = {2'b00, w_in[j].mag} >=
                            (34'(m) * {2'b00, i2a_pkg::C_POW10[j]});
                if (w_ge[m-1]) begin
                    w_sub = 32'(34'(m) * {2'b00, i2a_pkg::C_POW10[j]});
                end
            end
            w_dig = 4'($countones(w_ge));
        end

        // remove this digit and shift it in
        always_comb begin
            n_st[j]      = w_in[j];
            n_st[j].mag  = w_in[j].mag - w_sub;
            n_st[j].digs = {w_in[j].digs[4*i2a_pkg::NDIG-5:0], w_dig};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= w_vin[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j] && w_vin[j]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[i2a_pkg::NDIG-1];
    assign o_st    = r_st[i2a_pkg::NDIG-1];

endmodule

// ===== rtl/i2a_pack.sv =====
// ----------------------------------------------------------------------------
// i2a_pack
// Line builder: suppresses leading zeros, places the minus sign, and lays
// out the character line with the final character in the last slot.
// ----------------------------------------------------------------------------
module i2a_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2a_pkg::t_dstage    i_st,
    output logic                o_valid,
    output i2a_pkg::t_line      o_line,
    input  logic                i_ready
);

    logic               r_v;
    i2a_pkg::t_line     r_line;
    i2a_pkg::t_line     n_line;
    i2a_pkg::t_idx      w_lead;
    logic [3:0]         w_dig [i2a_pkg::NDIG];

    assign o_ready = !r_v || i_ready;

    // split the digits, most significant first
    always_comb begin
        for (int k = 0; k < i2a_pkg::NDIG; k++) begin
            w_dig[k] = i_st.digs[4*(i2a_pkg::NDIG-1-k) +: 4];
        end
    end

    // find the first nonzero digit; the units digit always stays
    always_comb begin
        w_lead = i2a_pkg::t_idx'(i2a_pkg::NDIG - 1);
        for (int k = i2a_pkg::NDIG - 1; k >= 0; k--) begin
            if (w_dig[k] != 4'd0) begin
                w_lead = i2a_pkg::t_idx'(k);
            end
        end
    end

    // lay out the line
    always_comb begin
        n_line = '0;
        if (i_st.ctx.is_dec) begin
            n_line.chars[0] = i2a_pkg::C_MINUS;
            for (int k = 1; k < i2a_pkg::NBUF; k++) begin
                n_line.chars[k] = i2a_pkg::C_ZERO | {4'b0, w_dig[k-1]};
                if (i_st.ctx.neg && (i2a_pkg::t_idx'(k) == w_lead)) begin
                    n_line.chars[k] = i2a_pkg::C_MINUS;
                end
            end
            n_line.first = i_st.ctx.neg ? w_lead : (w_lead + 4'd1);
        end else begin
            for (int k = 0; k < 5; k++) begin
                n_line.chars[i2a_pkg::NBUF-1-k] = i_st.ctx.fix[k];
            end
            n_line.first = i_st.ctx.fix_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_line <= n_line;
        end
    end

    assign o_valid = r_v;
    assign o_line  = r_line;

endmodule

// ===== rtl/i2a_ser.sv =====
// ----------------------------------------------------------------------------
// i2a_ser
// Output serializer: walks one character line from its first slot to the
// last, one beat per character, and loads the next line on the final beat.
// ----------------------------------------------------------------------------
module i2a_ser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2a_pkg::t_line      i_line,
    output logic                o_tvalid,
    input  logic                i_tready,
    output i2a_pkg::t_char      o_ch,
    output logic                o_last
);

    logic                       r_busy;
    i2a_pkg::t_idx              r_idx;
    i2a_pkg::t_char [i2a_pkg::NBUF-1:0] r_chars;
    logic                       w_last;
    logic                       w_load;

    assign w_last  = (r_idx == i2a_pkg::C_LAST_IDX);
    assign o_ready = !r_busy || (i_tready && w_last);
    assign w_load  = o_ready && i_valid;

    // advance through the line, reload on the final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= i2a_pkg::C_LAST_IDX;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= i_line.first;
        end else if (r_busy && i_tready) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_chars <= i_line.chars;
        end
    end

    assign o_tvalid = r_busy;
    assign o_ch     = r_chars[r_idx];
    assign o_last   = w_last;

    // the beat index never runs past the final slot
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= i2a_pkg::C_LAST_IDX))
        else $error("serializer index beyond final slot");

    // a loaded line starts inside the line
    a_first_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (i_line.first <= i2a_pkg::C_LAST_IDX))
        else $error("line start beyond final slot");

    // a stalled beat keeps its slot
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_tready) |=> (r_busy && (r_idx == $past(r_idx))))
        else $error("serializer moved during stall");

    // index steps by one between beats of the same line
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_tready && !w_last) |=> (r_idx == $past(r_idx) + 4'd1))
        else $error("serializer skipped a character");

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns one integer conversion request into a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the conversion kind,
//   tdata the 32-bit operand and the width digit. Characters leave on the
//   m_axis channel one per beat, with tlast on the final character of each
//   conversion. i_cfg_we/i_cfg_wdata write the output enable; while it is
//   low, accepted requests are dropped and produce no beats.
// Pipeline and throughput:
//   One decode stage, ten digit stages (one per power of ten) and one
//   line-builder stage feed the serializer. A request occupies the output
//   for one beat per character (1 to 11 characters); the serializer sends
//   one character per cycle while m_axis_tready is high. Up to 13 requests
//   are in flight at once.
// Reset and stall:
//   Reset empties the pipeline and clears the output enable. When the
//   receiver holds m_axis_tready low, the current character holds, the
//   stages fill up behind it and s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [35:32] width, [39:36] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] ch
    output logic        m_axis_tlast
);

    logic               r_out_en;
    logic               w_p_valid;
    logic               w_p_ready;
    i2a_pkg::t_dstage   w_p_st;
    logic               w_d_valid;
    logic               w_d_ready;
    i2a_pkg::t_dstage   w_d_st;
    logic               w_l_valid;
    logic               w_l_ready;
    i2a_pkg::t_line     w_line;

    // output enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_out_en <= i_cfg_wdata;
        end
    end

    i2a_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (i2a_pkg::t_cmd'(s_axis_tuser)),
        .i_value  (s_axis_tdata[31:0]),
        .i_width  (s_axis_tdata[35:32]),
        .i_out_en (r_out_en),
        .o_valid  (w_p_valid),
        .o_st     (w_p_st),
        .i_ready  (w_p_ready)
    );

    i2a_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_p_valid),
        .o_ready  (w_p_ready),
        .i_st     (w_p_st),
        .o_valid  (w_d_valid),
        .o_st     (w_d_st),
        .i_ready  (w_d_ready)
    );

    i2a_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_d_valid),
        .o_ready  (w_d_ready),
        .i_st     (w_d_st),
        .o_valid  (w_l_valid),
        .o_line   (w_line),
        .i_ready  (w_l_ready)
    );

    i2a_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_l_valid),
        .o_ready  (w_l_ready),
        .i_line   (w_line),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_ch     (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule
